// ----- design/lph_pkg.sv -----
// shared types, codes and defaults for the linear probing hash table
package lph_pkg;

    localparam int SLOT_COUNT_DEF = 512;
    localparam int KEY_W          = 32;
    localparam int VAL_W          = 32;
    localparam int SLOT_OUT_W     = 9;
    localparam int COUNT_OUT_W    = 9;

    localparam logic [1:0] OPC_INSERT = 2'd0;
    localparam logic [1:0] OPC_LOOKUP = 2'd1;
    localparam logic [1:0] OPC_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       opcode;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]             status;
        logic [VAL_W-1:0]       read_value;
        logic [SLOT_OUT_W-1:0]  slot_index;
        logic [COUNT_OUT_W-1:0] entry_count;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } slot_t;

endpackage

// ----- design/lph_hash.sv -----
// home slot unit: key modulo the slot count, mask or multi-cycle reduction
module lph_hash #(
    parameter int SLOT_COUNT = lph_pkg::SLOT_COUNT_DEF,
    parameter int IW         = $clog2(SLOT_COUNT)
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [lph_pkg::KEY_W-1:0] key,
    output logic [IW-1:0]           home,
    output logic                    done
);
    import lph_pkg::*;

    localparam bit IS_POW2 = (SLOT_COUNT & (SLOT_COUNT - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic [IW-1:0] home_reg;
            logic          done_reg;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    home_reg <= key[IW-1:0];
                end
            end

            assign home = home_reg;
            assign done = done_reg;
        end
        else begin : g_reduce
            localparam int RW     = IW + 1;
            localparam int BPC    = 8;
            localparam int ROUNDS = KEY_W / BPC;
            localparam int CNT_W  = $clog2(ROUNDS);

            logic [RW-1:0]    rem_reg;
            logic [RW-1:0]    rem_next;
            logic [KEY_W-1:0] bits_reg;
            logic [KEY_W-1:0] bits_next;
            logic [CNT_W-1:0] cnt_reg;
            logic             run_reg;
            logic             done_reg;

            // eight restoring steps, one key bit each
            always_comb
            begin
                rem_next  = rem_reg;
                bits_next = bits_reg;
                for (int i = 0; i < BPC; i++)
                begin
                    rem_next  = {rem_next[RW-2:0], bits_next[KEY_W-1]};
                    bits_next = bits_next << 1;
                    if (rem_next >= RW'(SLOT_COUNT))
                    begin
                        rem_next = rem_next - RW'(SLOT_COUNT);
                    end
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    run_reg  <= 1'b0;
                    cnt_reg  <= '0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        run_reg <= 1'b1;
                        cnt_reg <= '0;
                    end
                    else if (run_reg)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                        if (cnt_reg == CNT_W'(ROUNDS - 1))
                        begin
                            run_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    rem_reg  <= '0;
                    bits_reg <= key;
                end
                else if (run_reg)
                begin
                    rem_reg  <= rem_next;
                    bits_reg <= bits_next;
                end
            end

            assign home = rem_reg[IW-1:0];
            assign done = done_reg;
        end
    endgenerate

endmodule

// ----- design/linear_probe_hash_table.sv -----
// open addressing hash table with linear probing, top level
//
// command beat: cmd (opcode, key, value) is taken at a clock edge where start
// is high and busy is low. one result beat per command appears on result for
// exactly one cycle with done high; the receiver cannot stall it.
// after reset the block clears every slot key, one slot per cycle, and holds
// busy high until the clearing pass is done, before the first command is taken.
// steps per command, from the accepting edge to the done cycle:
//   key zero, unknown opcode or refused insert: answered from idle, no probe
//   insert or lookup: the home slot (a mask for a power of two slot count,
//   else the reduction), then a probe of each slot until the search ends
//   remove: as lookup, then for every entry that follows the removed one in
//   its cluster a read, a new home slot, a probe of each slot to place it
//   and a clear of its old slot if it moves, up to the empty slot at its end
// the single slot memory (one write, one registered read per cycle) and the
// home slot unit pace the work: one probe per cycle. one command at a
// time; the next command may be taken in the cycle its result is shown.
module linear_probe_hash_table #(
    parameter int SLOT_COUNT = lph_pkg::SLOT_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lph_pkg::cmd_t cmd,
    output logic          done,
    output lph_pkg::rsp_t result
);
    import lph_pkg::*;

    localparam int IW = $clog2(SLOT_COUNT);
    localparam int CW = $clog2(SLOT_COUNT + 1);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_SRCH  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_RHASH = 3'd5;
    localparam logic [2:0] S_PLACE = 3'd6;
    localparam logic [2:0] S_ZERO  = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [IW-1:0]    probe_reg, probe_next;
    logic [IW-1:0]    scan_reg, scan_next;
    logic [IW-1:0]    hit_reg, hit_next;
    logic [KEY_W-1:0] mk_reg, mk_next;
    logic [VAL_W-1:0] mv_reg, mv_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [IW-1:0]    clr_reg, clr_next;
    rsp_t             rsp_reg, rsp_next;
    logic             done_reg, done_next;

    slot_t            mem [SLOT_COUNT];
    slot_t            rdata_reg;
    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    slot_t            mem_wdata;
    logic [IW-1:0]    mem_raddr;

    logic             hash_start;
    logic [KEY_W-1:0] hash_key;
    logic [IW-1:0]    hash_home;
    logic             hash_done;

    logic [IW-1:0]    probe_adv;
    logic [IW-1:0]    scan_adv;
    logic             table_full;

    lph_hash #(
        .SLOT_COUNT (SLOT_COUNT),
        .IW         (IW)
    ) u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .start (hash_start),
        .key   (hash_key),
        .home  (hash_home),
        .done  (hash_done)
    );

    assign probe_adv  = (probe_reg == IW'(SLOT_COUNT - 1)) ? '0 : probe_reg + 1'b1;
    assign scan_adv   = (scan_reg == IW'(SLOT_COUNT - 1)) ? '0 : scan_reg + 1'b1;
    assign table_full = ({1'b0, count_reg} << 1) >= (CW + 1)'(SLOT_COUNT);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        val_next   = val_reg;
        probe_next = probe_reg;
        scan_next  = scan_reg;
        hit_next   = hit_reg;
        mk_next    = mk_reg;
        mv_next    = mv_reg;
        count_next = count_reg;
        clr_next   = clr_reg;
        rsp_next   = rsp_reg;
        done_next  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = probe_reg;
        mem_wdata  = '0;
        mem_raddr  = probe_adv;
        hash_start = 1'b0;
        hash_key   = mk_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IW'(SLOT_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    op_next  = cmd.opcode;
                    key_next = cmd.key;
                    val_next = cmd.value;
                    if (cmd.key == '0 ||
                        !(cmd.opcode inside {OPC_INSERT, OPC_LOOKUP, OPC_REMOVE}))
                    begin
                        done_next            = 1'b1;
                        rsp_next.status      = ST_NOT_FOUND;
                        rsp_next.read_value  = '0;
                        rsp_next.slot_index  = '0;
                        rsp_next.entry_count = COUNT_OUT_W'(count_reg);
                    end
                    else if (cmd.opcode == OPC_INSERT && table_full)
                    begin
                        done_next            = 1'b1;
                        rsp_next.status      = ST_FULL;
                        rsp_next.read_value  = '0;
                        rsp_next.slot_index  = '0;
                        rsp_next.entry_count = COUNT_OUT_W'(count_reg);
                    end
                    else
                    begin
                        hash_start = 1'b1;
                        hash_key   = cmd.key;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    mem_raddr  = hash_home;
                    probe_next = hash_home;
                    state_next = S_SRCH;
                end
            end
            S_SRCH:
            begin
                probe_next = probe_adv;
                case (op_reg)
                    OPC_INSERT:
                    begin
                        if (rdata_reg.key == '0)
                        begin
                            mem_we               = 1'b1;
                            mem_wdata.key        = key_reg;
                            mem_wdata.value      = val_reg;
                            count_next           = count_reg + 1'b1;
                            done_next            = 1'b1;
                            rsp_next.status      = ST_OK;
                            rsp_next.read_value  = '0;
                            rsp_next.slot_index  = SLOT_OUT_W'(probe_reg);
                            rsp_next.entry_count = COUNT_OUT_W'(count_reg + 1'b1);
                            state_next           = S_IDLE;
                        end
                    end
                    OPC_LOOKUP:
                    begin
                        if (rdata_reg.key == key_reg || rdata_reg.key == '0)
                        begin
                            done_next            = 1'b1;
                            rsp_next.slot_index  = SLOT_OUT_W'(probe_reg);
                            rsp_next.entry_count = COUNT_OUT_W'(count_reg);
                            state_next           = S_IDLE;
                            if (rdata_reg.key == key_reg)
                            begin
                                rsp_next.status     = ST_OK;
                                rsp_next.read_value = rdata_reg.value;
                            end
                            else
                            begin
                                rsp_next.status     = ST_NOT_FOUND;
                                rsp_next.read_value = '0;
                            end
                        end
                    end
                    default:
                    begin
                        if (rdata_reg.key == key_reg)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg - 1'b1;
                            hit_next   = probe_reg;
                            scan_next  = probe_adv;
                            state_next = S_SCAN;
                        end
                        else if (rdata_reg.key == '0)
                        begin
                            done_next            = 1'b1;
                            rsp_next.status      = ST_NOT_FOUND;
                            rsp_next.read_value  = '0;
                            rsp_next.slot_index  = SLOT_OUT_W'(probe_reg);
                            rsp_next.entry_count = COUNT_OUT_W'(count_reg);
                            state_next           = S_IDLE;
                        end
                    end
                endcase
            end
            S_SCAN:
            begin
                if (rdata_reg.key == '0)
                begin
                    done_next            = 1'b1;
                    rsp_next.status      = ST_OK;
                    rsp_next.read_value  = '0;
                    rsp_next.slot_index  = SLOT_OUT_W'(hit_reg);
                    rsp_next.entry_count = COUNT_OUT_W'(count_reg);
                    state_next           = S_IDLE;
                end
                else
                begin
                    mk_next    = rdata_reg.key;
                    mv_next    = rdata_reg.value;
                    hash_start = 1'b1;
                    hash_key   = rdata_reg.key;
                    state_next = S_RHASH;
                end
            end
            S_RHASH:
            begin
                if (hash_done)
                begin
                    mem_raddr  = hash_home;
                    probe_next = hash_home;
                    state_next = S_PLACE;
                end
            end
            S_PLACE:
            begin
                probe_next = probe_adv;
                // the entry's own slot counts as empty while it is moved
                if (probe_reg == scan_reg)
                begin
                    mem_raddr  = scan_adv;
                    scan_next  = scan_adv;
                    state_next = S_SCAN;
                end
                else if (rdata_reg.key == '0)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.key   = mk_reg;
                    mem_wdata.value = mv_reg;
                    state_next      = S_ZERO;
                end
            end
            S_ZERO:
            begin
                mem_we     = 1'b1;
                mem_waddr  = scan_reg;
                mem_raddr  = scan_adv;
                scan_next  = scan_adv;
                state_next = S_SCAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            count_reg <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        val_reg   <= val_next;
        probe_reg <= probe_next;
        scan_reg  <= scan_next;
        hit_reg   <= hit_next;
        mk_reg    <= mk_next;
        mv_reg    <= mv_next;
        rsp_reg   <= rsp_next;
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = rsp_reg;

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result beat while a command is still in work");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, count_reg} << 1) <= (CW + 1)'(SLOT_COUNT + 1))
        else $error("entry count above half the slot count");

    a_full_reason: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FULL |-> table_full)
        else $error("full status while the table has room");

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !done && count_reg == '0)
        else $error("activity during the clearing pass");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> count_reg == $past(count_reg))
        else $error("entry count changed outside an operation");
`endif

endmodule

// ----- verif/tb_linear_probe_hash_table.sv -----
// self-checking testbench for the linear probing hash table: directed table, then random phases
`timescale 1ns / 100ps

module tb_linear_probe_hash_table;

    import lph_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam logic [1:0] OPC_UNUSED = 2'd3;
    localparam int TOTAL_ITEMS = 1850;
    localparam int DIR_ROWS = 22;

    typedef struct {
        cmd_t c;
        bit   typed;
        rsp_t want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    cmd_t cmd = '0;
    logic busy;
    logic done;
    rsp_t result;

    linear_probe_hash_table dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the table
    logic [31:0] shadow_keys [SLOTS];
    logic [31:0] shadow_vals [SLOTS];
    int unsigned shadow_count;

    rsp_t pending_replies [$];
    rsp_t oldest_reply;
    int mismatches;
    int items_sent;
    int lookup_hits, lookup_misses, removes_done, inserts_done, inserts_refused, ignored;
    int burst_left;
    bit pacing;
    int unsigned cluster_base;

    // extremes, key zero, unknown opcode, wraparound, duplicates, cluster repair
    dir_row_t directed_rows [DIR_ROWS] = '{
        '{'{OPC_LOOKUP, 32'd7, 32'd0}, 1'b1, '{ST_NOT_FOUND, 32'd0, 9'd7, 9'd0}},
        '{'{OPC_REMOVE, 32'd7, 32'd0}, 1'b1, '{ST_NOT_FOUND, 32'd0, 9'd7, 9'd0}},
        '{'{OPC_INSERT, 32'd0, 32'hFFFF_FFFF}, 1'b1, '{ST_NOT_FOUND, 32'd0, 9'd0, 9'd0}},
        '{'{OPC_LOOKUP, 32'd0, 32'd0}, 1'b1, '{ST_NOT_FOUND, 32'd0, 9'd0, 9'd0}},
        '{'{OPC_REMOVE, 32'd0, 32'd0}, 1'b1, '{ST_NOT_FOUND, 32'd0, 9'd0, 9'd0}},
        '{'{OPC_UNUSED, 32'd9, 32'd1}, 1'b1, '{ST_NOT_FOUND, 32'd0, 9'd0, 9'd0}},
        '{'{OPC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{ST_OK, 32'd0, 9'd511, 9'd1}},
        '{'{OPC_INSERT, 32'd1, 32'd0}, 1'b1, '{ST_OK, 32'd0, 9'd1, 9'd2}},
        '{'{OPC_INSERT, 32'd511, 32'h1234_5678}, 1'b0, '0},
        '{'{OPC_INSERT, 32'd1023, 32'hDEAD_BEEF}, 1'b0, '0},
        '{'{OPC_LOOKUP, 32'd1023, 32'd0}, 1'b0, '0},
        '{'{OPC_INSERT, 32'd1, 32'd5}, 1'b0, '0},
        '{'{OPC_LOOKUP, 32'd1, 32'd0}, 1'b0, '0},
        '{'{OPC_REMOVE, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
        '{'{OPC_LOOKUP, 32'd511, 32'd0}, 1'b0, '0},
        '{'{OPC_LOOKUP, 32'd1023, 32'd0}, 1'b0, '0},
        '{'{OPC_REMOVE, 32'd1, 32'd0}, 1'b0, '0},
        '{'{OPC_LOOKUP, 32'd1, 32'd0}, 1'b0, '0},
        '{'{OPC_LOOKUP, 32'hFFFF_FFFF, 32'd0}, 1'b0, '0},
        '{'{OPC_INSERT, 32'h8000_0000, 32'hAAAA_5555}, 1'b0, '0},
        '{'{OPC_UNUSED, 32'd0, 32'd0}, 1'b0, '0},
        '{'{OPC_LOOKUP, 32'd512, 32'd0}, 1'b0, '0}
    };

    function automatic bit find_key(input logic [31:0] k, output int unsigned where);
        int unsigned s;
        s = k % SLOTS;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_keys[s] == k)
            begin
                where = s;
                return 1'b1;
            end
            if (shadow_keys[s] == '0)
            begin
                where = s;
                return 1'b0;
            end
            s = (s + 1) % SLOTS;
        end
        where = k % SLOTS;
        return 1'b0;
    endfunction

    function automatic int unsigned place_entry(input logic [31:0] k, input logic [31:0] v);
        int unsigned s;
        s = k % SLOTS;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_keys[s] == '0)
                break;
            s = (s + 1) % SLOTS;
        end
        shadow_keys[s] = k;
        shadow_vals[s] = v;
        return s;
    endfunction

    function automatic rsp_t hash_table_op(input cmd_t c);
        rsp_t r;
        int unsigned s, n;
        logic [31:0] mk, mv;
        r = '0;
        r.status = ST_NOT_FOUND;
        s = 0;
        if (c.key != '0)
        begin
            case (c.opcode)
                OPC_INSERT:
                    if (shadow_count * 2 >= SLOTS)
                        r.status = ST_FULL;
                    else
                    begin
                        s = place_entry(c.key, c.value);
                        shadow_count++;
                        r.status = ST_OK;
                    end
                OPC_LOOKUP:
                    if (find_key(c.key, s))
                    begin
                        r.status = ST_OK;
                        r.read_value = shadow_vals[s];
                    end
                OPC_REMOVE:
                    if (find_key(c.key, s))
                    begin
                        shadow_keys[s] = '0;
                        shadow_count--;
                        n = (s + 1) % SLOTS;
                        // pull the rest of the cluster back toward home
                        for (int i = 0; i < SLOTS && shadow_keys[n] != '0; i++)
                        begin
                            mk = shadow_keys[n];
                            mv = shadow_vals[n];
                            shadow_keys[n] = '0;
                            void'(place_entry(mk, mv));
                            n = (n + 1) % SLOTS;
                        end
                        r.status = ST_OK;
                    end
                default: ;
            endcase
        end
        r.slot_index = 9'(s);
        r.entry_count = 9'(shadow_count);
        return r;
    endfunction

    function automatic logic [31:0] stored_key();
        int unsigned s;
        do
            s = $urandom_range(SLOTS - 1, 0);
        while (shadow_keys[s] == '0);
        return shadow_keys[s];
    endfunction

    function automatic logic [31:0] fresh_key();
        logic [31:0] k;
        k = $urandom;
        if ($urandom_range(99, 0) < 20)
            k[8:0] = 9'((cluster_base + $urandom_range(15, 0)) % SLOTS);
        if (k == '0)
            k = 32'd1;
        return k;
    endfunction

    function automatic cmd_t random_beat(int ins, int lkp, int rem, int hit_pct);
        cmd_t c;
        int roll;
        roll = $urandom_range(99, 0);
        c.value = $urandom;
        if (roll < ins)
        begin
            c.opcode = OPC_INSERT;
            c.key = (shadow_count != 0 && $urandom_range(9, 0) == 0) ? stored_key()
                                                                     : fresh_key();
        end
        else if (roll < ins + lkp + rem)
        begin
            c.opcode = (roll < ins + lkp) ? OPC_LOOKUP : OPC_REMOVE;
            c.key = (shadow_count != 0 && $urandom_range(99, 0) < hit_pct) ? stored_key()
                                                                           : fresh_key();
        end
        else if ($urandom_range(1, 0) == 1)
        begin
            c.opcode = OPC_UNUSED;
            c.key = $urandom;
        end
        else
        begin
            c.opcode = 2'($urandom_range(3, 0));
            c.key = '0;
        end
        return c;
    endfunction

    task automatic send_beat(input cmd_t c, input bit typed, input rsp_t want);
        rsp_t guess;
        start <= 1'b1;
        cmd <= c;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        guess = hash_table_op(c);
        pending_replies.push_back(typed ? want : guess);
        items_sent++;
        if (c.key == '0 || c.opcode == OPC_UNUSED)
            ignored++;
        else if (c.opcode == OPC_INSERT)
        begin
            if (guess.status == ST_FULL)
                inserts_refused++;
            else
                inserts_done++;
        end
        else if (c.opcode == OPC_LOOKUP)
        begin
            if (guess.status == ST_OK)
                lookup_hits++;
            else
                lookup_misses++;
        end
        else if (guess.status == ST_OK)
            removes_done++;
    endtask

    task automatic idle(input int n);
        start <= 1'b0;
        cmd <= '{opcode: 2'($urandom), key: $urandom, value: $urandom};
        repeat (n) @(posedge clk);
    endtask

    task automatic pace_beat(input cmd_t c);
        send_beat(c, 1'b0, '0);
        if (pacing)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                idle(($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(6, 1));
                burst_left = $urandom_range(24, 1);
            end
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_replies.size() != 0);
    endtask

    // result beat checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                $error("result beat with nothing outstanding: %p", result);
            end
            else
            begin
                oldest_reply = pending_replies.pop_front();
                if (result.status !== oldest_reply.status)
                begin
                    mismatches++;
                    $error("status: expected %0d, got %0d", oldest_reply.status, result.status);
                end
                if (result.read_value !== oldest_reply.read_value)
                begin
                    mismatches++;
                    $error("read_value: expected %h, got %h", oldest_reply.read_value,
                           result.read_value);
                end
                if (result.slot_index !== oldest_reply.slot_index)
                begin
                    mismatches++;
                    $error("slot_index: expected %0d, got %0d", oldest_reply.slot_index,
                           result.slot_index);
                end
                if (result.entry_count !== oldest_reply.entry_count)
                begin
                    mismatches++;
                    $error("entry_count: expected %0d, got %0d", oldest_reply.entry_count,
                           result.entry_count);
                end
            end
        end
    end

    initial
    begin
        int refused_mark;
        int phase_items;
        foreach (shadow_keys[i])
        begin
            shadow_keys[i] = '0;
            shadow_vals[i] = '0;
        end
        shadow_count = 0;
        mismatches = 0;
        items_sent = 0;
        burst_left = 8;
        pacing = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(directed_rows[i].c, directed_rows[i].typed, directed_rows[i].want);
        wait_drained();

        // mixed traffic at moderate load
        cluster_base = $urandom_range(SLOTS - 1, 0);
        for (int i = 0; i < 500; i++)
            pace_beat(random_beat(40, 35, 20, 70));
        wait_drained();

        // fill to half load, back to back, cluster across the wrap point
        pacing = 1'b0;
        cluster_base = SLOTS - 12;
        refused_mark = inserts_refused;
        phase_items = 0;
        while (inserts_refused - refused_mark < 12 && phase_items < 500)
        begin
            send_beat(random_beat(85, 10, 0, 70), 1'b0, '0);
            phase_items++;
        end
        wait_drained();

        // churn at the half-load limit
        pacing = 1'b1;
        for (int i = 0; i < 300; i++)
            pace_beat(random_beat(45, 20, 30, 80));
        wait_drained();

        // empty the table
        phase_items = 0;
        while (shadow_count != 0 && phase_items < 700)
        begin
            pace_beat(random_beat(0, 20, 75, 90));
            phase_items++;
        end
        wait_drained();

        cluster_base = $urandom_range(SLOTS - 1, 0);
        while (items_sent < TOTAL_ITEMS)
            pace_beat(random_beat(40, 35, 20, 70));
        wait_drained();
        repeat (20) @(posedge clk);

        if (pending_replies.size() != 0)
            mismatches++;
        $display("covered %0d commands: %0d inserts, %0d refused at half load, %0d removes",
                 items_sent, inserts_done, inserts_refused, removes_done);
        $display("lookups: %0d hits, %0d misses; %0d ignored commands", lookup_hits,
                 lookup_misses, ignored);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #100_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ----- files.f -----
design/lph_pkg.sv
design/lph_hash.sv
design/linear_probe_hash_table.sv
verif/tb_linear_probe_hash_table.sv
